// ----- rtl/core/ptc_pkg.sv -----
// ptc_pkg: shared types, codes and constants for the player transport controller.
// No dependencies; imported by every module of the block.
package ptc_pkg;

    localparam int CMD_LENGTH = 4;
    localparam int RX_CNT_W   = $clog2(CMD_LENGTH + 1);

    localparam logic [RX_CNT_W-1:0] CMD_LEN_C   = RX_CNT_W'(CMD_LENGTH);
    localparam logic [RX_CNT_W-1:0] RX_CNT_ONE  = RX_CNT_W'(1);
    localparam logic [RX_CNT_W-1:0] RX_CNT_TWO  = RX_CNT_W'(2);

    localparam logic [7:0] CH_P  = 8'h50;
    localparam logic [7:0] CH_A  = 8'h41;
    localparam logic [7:0] CH_L  = 8'h4C;
    localparam logic [7:0] CH_NL = 8'h0A;

    localparam logic [15:0] HOLD_MAX = 16'hFFFF;

    localparam int         SEC_PER_MIN = 60;
    localparam logic [5:0] CLK_LAST    = 6'(SEC_PER_MIN - 1);

    localparam logic [7:0]  TPS_RESET   = 8'd100;
    localparam logic [15:0] SHORT_RESET = 16'd30;
    localparam logic [15:0] LONG_RESET  = 16'd100;

    // configuration register indexes
    localparam logic [1:0] CFG_TPS   = 2'd0;
    localparam logic [1:0] CFG_SHORT = 2'd1;
    localparam logic [1:0] CFG_LONG  = 2'd2;

    typedef enum logic [1:0] {
        ACT_TICK = 2'd0,
        ACT_BYTE = 2'd1,
        ACT_BTN1 = 2'd2,
        ACT_BTN2 = 2'd3
    } t_action;

    // press classes; report code is button base plus class
    localparam logic [1:0] CLS_SHORT  = 2'd1;
    localparam logic [1:0] CLS_MEDIUM = 2'd2;
    localparam logic [1:0] CLS_LONG   = 2'd3;

    localparam logic [2:0] REP_NONE      = 3'd0;
    localparam logic [2:0] BTN_ONE_BASE  = 3'd0;
    localparam logic [2:0] BTN_TWO_BASE  = 3'd3;

    typedef struct packed {
        logic [7:0]  ticks_per_second;
        logic [15:0] short_limit;
        logic [15:0] long_limit;
    } t_cfg;

    typedef struct packed {
        t_action    action;
        logic [7:0] rx_byte;
        logic       pressed;
    } t_item;

    typedef struct packed {
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic       running;
        logic [2:0] report_code;
        logic       time_changed;
    } t_result;

endpackage

// ----- rtl/core/ptc_cfg_regs.sv -----
// ptc_cfg_regs: configuration register file (tick prescale and press limits).
// Depends on ptc_pkg.
module ptc_cfg_regs
    import ptc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_wdata,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TPS:   n_cfg.ticks_per_second = i_cfg_wdata[7:0];
                CFG_SHORT: n_cfg.short_limit      = i_cfg_wdata;
                CFG_LONG:  n_cfg.long_limit       = i_cfg_wdata;
                default:   n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ticks_per_second <= TPS_RESET;
            r_cfg.short_limit      <= SHORT_RESET;
            r_cfg.long_limit       <= LONG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/core/ptc_engine.sv -----
// ptc_engine: play clock, command buffer and button hold state with the
// single-pass update for one item. Depends on ptc_pkg.
module ptc_engine
    import ptc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    logic [RX_CNT_W-1:0] r_rx_count, n_rx_count;
    logic [7:0]          r_first_char, n_first_char;
    logic [7:0]          r_second_char, n_second_char;
    logic [7:0]          r_prescale, n_prescale;
    logic [5:0]          r_sec, n_sec;
    logic [5:0]          r_min, n_min;
    logic                r_run, n_run;
    logic                r_held1, n_held1;
    logic                r_held2, n_held2;
    logic [15:0]         r_hold1, n_hold1;
    logic [15:0]         r_hold2, n_hold2;

    logic [2:0]  report;
    logic        changed;
    logic [7:0]  pre_inc;
    logic        stored;
    logic [15:0] hold_sel;
    logic [1:0]  cls;

    always_comb begin
        n_rx_count    = r_rx_count;
        n_first_char  = r_first_char;
        n_second_char = r_second_char;
        n_prescale    = r_prescale;
        n_sec         = r_sec;
        n_min         = r_min;
        n_run         = r_run;
        n_held1       = r_held1;
        n_held2       = r_held2;
        n_hold1       = r_hold1;
        n_hold2       = r_hold2;
        report        = REP_NONE;
        changed       = 1'b0;
        pre_inc       = r_prescale + 8'd1;
        stored        = (i_item.rx_byte != 8'd0) && (r_rx_count < CMD_LEN_C);
        hold_sel      = (i_item.action == ACT_BTN1) ? r_hold1 : r_hold2;

        if (hold_sel < i_cfg.short_limit) begin
            cls = CLS_SHORT;
        end else if (hold_sel < i_cfg.long_limit) begin
            cls = CLS_MEDIUM;
        end else begin
            cls = CLS_LONG;
        end

        unique case (i_item.action)
            ACT_TICK: begin
                if (r_held1 && r_hold1 != HOLD_MAX) n_hold1 = r_hold1 + 16'd1;
                if (r_held2 && r_hold2 != HOLD_MAX) n_hold2 = r_hold2 + 16'd1;
                if (r_run) begin
                    if (pre_inc < i_cfg.ticks_per_second) begin
                        n_prescale = pre_inc;
                    end else begin
                        n_prescale = 8'd0;
                        changed    = 1'b1;
                        if (r_sec == CLK_LAST) begin
                            n_sec = 6'd0;
                            n_min = (r_min == CLK_LAST) ? 6'd0 : r_min + 6'd1;
                        end else begin
                            n_sec = r_sec + 6'd1;
                        end
                    end
                end
            end
            ACT_BYTE: begin
                if (stored) begin
                    if (r_rx_count == '0)        n_first_char  = i_item.rx_byte;
                    if (r_rx_count == RX_CNT_ONE) n_second_char = i_item.rx_byte;
                    n_rx_count = r_rx_count + RX_CNT_ONE;
                end
                if (n_rx_count == RX_CNT_TWO && n_first_char == CH_P &&
                    (n_second_char == CH_A || n_second_char == CH_L)) begin
                    n_run         = (n_second_char == CH_L);
                    n_rx_count    = '0;
                    n_first_char  = 8'd0;
                    n_second_char = 8'd0;
                end else if (n_rx_count == CMD_LEN_C || i_item.rx_byte == CH_NL) begin
                    if (n_rx_count == CMD_LEN_C) begin
                        n_sec = 6'd0;
                        n_min = 6'd0;
                    end
                    n_rx_count    = '0;
                    n_first_char  = 8'd0;
                    n_second_char = 8'd0;
                end
            end
            ACT_BTN1, ACT_BTN2: begin
                if (i_item.pressed) begin
                    if (i_item.action == ACT_BTN1) begin
                        n_held1 = 1'b1;
                        n_hold1 = 16'd0;
                    end else begin
                        n_held2 = 1'b1;
                        n_hold2 = 16'd0;
                    end
                end else begin
                    if (i_item.action == ACT_BTN1) begin
                        n_held1 = 1'b0;
                        report  = BTN_ONE_BASE + {1'b0, cls};
                    end else begin
                        n_held2 = 1'b0;
                        report  = BTN_TWO_BASE + {1'b0, cls};
                    end
                    if (cls == CLS_SHORT) begin
                        n_sec = 6'd0;
                        n_min = 6'd0;
                        n_run = 1'b1;
                    end else if (cls == CLS_LONG) begin
                        // long press: button one plays, button two pauses
                        n_run = (i_item.action == ACT_BTN1);
                    end
                end
            end
            default: begin
                report = REP_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_count    <= '0;
            r_first_char  <= 8'd0;
            r_second_char <= 8'd0;
            r_prescale    <= 8'd0;
            r_sec         <= 6'd0;
            r_min         <= 6'd0;
            r_run         <= 1'b0;
            r_held1       <= 1'b0;
            r_held2       <= 1'b0;
            r_hold1       <= 16'd0;
            r_hold2       <= 16'd0;
        end else if (i_fire) begin
            r_rx_count    <= n_rx_count;
            r_first_char  <= n_first_char;
            r_second_char <= n_second_char;
            r_prescale    <= n_prescale;
            r_sec         <= n_sec;
            r_min         <= n_min;
            r_run         <= n_run;
            r_held1       <= n_held1;
            r_held2       <= n_held2;
            r_hold1       <= n_hold1;
            r_hold2       <= n_hold2;
        end
    end

    assign o_result.minutes      = n_min;
    assign o_result.seconds      = n_sec;
    assign o_result.running      = n_run;
    assign o_result.report_code  = report;
    assign o_result.time_changed = changed;

endmodule

// ----- rtl/core/player_transport_controller.sv -----
// player_transport_controller: top level with input and result registers.
// Depends on ptc_pkg, ptc_cfg_regs and ptc_engine.
//
// Accepts one transaction per cycle (tick, received byte or button edge) while
// o_in_stall is low and returns exactly one result per transaction: the play
// clock after the item, the running flag, a press report code and a one-second
// flag. An accepted item is held in the input register; the state update and
// the result are computed in one pass and land in the result register.
// Sustained rate is one item per cycle when the output is not stalled, set by
// the state update loop. Both registers hold under output stall; input stall
// rises only when both are full and the result is stalled. Configuration
// writes take effect on the next cycle.
module player_transport_controller
    import ptc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_pressed,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [5:0]  o_minutes,
    output logic [5:0]  o_seconds,
    output logic        o_running,
    output logic [2:0]  o_report_code,
    output logic        o_time_changed,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_wdata
);

    t_cfg    cfg;
    t_result eng_result;

    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_result;
    logic    advance;
    logic    fire;
    logic    in_load;

    assign advance    = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && advance;
    // input register takes a new item when empty or when its item moves on
    assign in_load    = advance || !r_in_valid;
    assign o_in_stall = !in_load;

    ptc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    ptc_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_item),
        .i_cfg    (cfg),
        .o_result (eng_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_load) begin
                r_in_valid  <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_item.action  <= t_action'(i_action);
            r_item.rx_byte <= i_rx_byte;
            r_item.pressed <= i_pressed;
        end
        if (fire) begin
            r_result <= eng_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_minutes      = r_result.minutes;
    assign o_seconds      = r_result.seconds;
    assign o_running      = r_result.running;
    assign o_report_code  = r_result.report_code;
    assign o_time_changed = r_result.time_changed;

endmodule
